[hdl/interpolation_search_macros.svh]
// assertion macros used by the checker file
`ifndef INTERPOLATION_SEARCH_MACROS_SVH
`define INTERPOLATION_SEARCH_MACROS_SVH

// property checked outside reset
`define ISRCH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("interpolation_search check failed");

// property checked at every edge, reset included
`define ISRCH_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("interpolation_search reset check failed");

`endif

[hdl/isrch_pkg.sv]
package isrch_pkg;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // input word
    typedef struct packed {
        logic        req_type;
        logic [9:0]  entry_index;
        logic [31:0] entry_value;
        logic [31:0] search_key;
        logic [9:0]  range_start;
        logic [10:0] range_end;
    } t_in_word;

    // output word
    typedef struct packed {
        logic       found;
        logic [9:0] position;
    } t_out_word;

    // microprogram
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_RD_LO,
        OP_RD_HI,
        OP_CAP_HI,
        OP_INIT_DIV,
        OP_DBL,
        OP_ADD,
        OP_MID,
        OP_RD_MID,
        OP_CMP,
        OP_SET_HIT,
        OP_SET_LO_POS,
        OP_SET_MISS,
        OP_DELIVER
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_SEARCH,
        C_EMPTY,
        C_LOOP_DONE,
        C_CNT_NZ,
        C_NE,
        C_KEY_EQ_LO,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // step addresses used as jump targets
    localparam t_pc PC_ACCEPT  = 4'd0;
    localparam t_pc PC_RD_LO   = 4'd1;
    localparam t_pc PC_DBL     = 4'd5;
    localparam t_pc PC_HIT     = 4'd10;
    localparam t_pc PC_FINAL   = 4'd11;
    localparam t_pc PC_MISS    = 4'd12;
    localparam t_pc PC_DELIVER = 4'd13;

    // control store: one word per step
    function automatic t_uword micro_rom(input t_pc pc);
        t_uword uw;
        unique case (pc)
            4'd0:    uw = '{OP_ACCEPT,     C_NO_SEARCH, PC_ACCEPT};
            4'd1:    uw = '{OP_RD_LO,      C_EMPTY,     PC_MISS};
            4'd2:    uw = '{OP_RD_HI,      C_NEXT,      PC_ACCEPT};
            4'd3:    uw = '{OP_CAP_HI,     C_NEXT,      PC_ACCEPT};
            4'd4:    uw = '{OP_INIT_DIV,   C_LOOP_DONE, PC_FINAL};
            4'd5:    uw = '{OP_DBL,        C_NEXT,      PC_ACCEPT};
            4'd6:    uw = '{OP_ADD,        C_CNT_NZ,    PC_DBL};
            4'd7:    uw = '{OP_MID,        C_NEXT,      PC_ACCEPT};
            4'd8:    uw = '{OP_RD_MID,     C_NEXT,      PC_ACCEPT};
            4'd9:    uw = '{OP_CMP,        C_NE,        PC_RD_LO};
            4'd10:   uw = '{OP_SET_HIT,    C_ALWAYS,    PC_DELIVER};
            4'd11:   uw = '{OP_SET_LO_POS, C_KEY_EQ_LO, PC_HIT};
            4'd12:   uw = '{OP_SET_MISS,   C_NEXT,      PC_ACCEPT};
            4'd13:   uw = '{OP_DELIVER,    C_OUT_FREE,  PC_ACCEPT};
            4'd14:   uw = '{OP_NOP,        C_ALWAYS,    PC_DELIVER};
            default: uw = '{OP_NOP,        C_ALWAYS,    PC_ACCEPT};
        endcase
        return uw;
    endfunction

endpackage

[hdl/interpolation_search.sv]
// interpolation search over a table held in block memory
// input channel (i_in_valid / o_in_ready / i_in_word) takes two kinds of word:
//   req_type write: stores entry_value at entry_index, gives no result;
//     an index past the table is dropped
//   req_type search: looks for search_key in [range_start, range_end),
//     range_end clamped to the table size, and gives one result word
// output channel (o_out_valid / i_out_ready / o_out_word) carries found and
// position; position is 0 when the key is not found
// a search runs through a microcoded sequencer that owns one memory read
// port and a bit-serial multiply-divide unit (one half step per cycle)
// each probe reads both range ends, runs the divider, then reads and compares
// the midpoint entry; a hit then sets found and delivers, while leaving the loop
// adds a compare of the key against the low-end value; an empty range goes
// straight from its low read to the miss and delivery steps
// one word is in work at a time: o_in_ready is high only at the fetch step
// a finished result sits in the output register while the next word is
// taken; a stalled receiver keeps the sequencer looping between its delivery
// step and a no-op step; reset clears the sequencer and the output valid; the
// table is not cleared and must be written before it is searched
module interpolation_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  isrch_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output isrch_pkg::t_out_word o_out_word
);
    import isrch_pkg::*;

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int VW   = VALUE_WIDTH;
    localparam int CNTW = $clog2(IW) + 1;
    localparam logic [31:0]     DEPTH32  = 32'(TABLE_DEPTH);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(IW - 1);

    // table memory
    logic [VW-1:0] r_mem [TABLE_DEPTH];
    logic [VW-1:0] r_rdata;

    // sequencer
    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_take;

    // search datapath
    logic [VW-1:0]   r_key, r_vlo, r_vhi;
    logic [IW-1:0]   r_low, r_high, r_mid, r_pos;
    logic            r_empty, r_found;
    logic [VW-1:0]   r_a, r_d, r_rem;
    logic [IW-1:0]   r_n, r_q;
    logic [CNTW-1:0] r_cnt;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    // input decode
    logic          w_accept;
    logic [31:0]   w_idx32, w_start32, w_end32, w_endc, w_last;
    logic [63:0]   w_key64, w_val64;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [IW-1:0] w_rd_addr;
    logic          w_out_free;
    logic          w_loop_done;
    logic [31:0]   w_pos32;

    // divider half steps
    logic [VW:0] w_dbl, w_dbl_sub, w_sum, w_sum_sub;
    logic        w_dbl_ge, w_sum_ge, w_nbit;

    assign w_uw       = micro_rom(r_pc);
    assign o_in_ready = (w_uw.op == OP_ACCEPT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_idx32   = 32'(i_in_word.entry_index);
    assign w_start32 = 32'(i_in_word.range_start);
    assign w_end32   = 32'(i_in_word.range_end);
    assign w_endc    = (w_end32 > DEPTH32) ? DEPTH32 : w_end32;
    assign w_last    = w_endc - 32'd1;
    assign w_key64   = 64'(i_in_word.search_key);
    assign w_val64   = 64'(i_in_word.entry_value);
    assign w_wr_en   = w_accept && (i_in_word.req_type == REQ_WRITE) &&
                       (w_idx32 < DEPTH32);

    assign w_loop_done = (r_vhi == r_vlo) || (r_key < r_vlo) || (r_key > r_vhi);

    // remainder doubling, then conditional add of the offset
    assign w_dbl     = {r_rem, 1'b0};
    assign w_dbl_ge  = w_dbl >= {1'b0, r_d};
    assign w_dbl_sub = w_dbl - {1'b0, r_d};
    assign w_nbit    = r_n[IW-1];
    assign w_sum     = {1'b0, r_rem} + {1'b0, r_a};
    assign w_sum_ge  = w_sum >= {1'b0, r_d};
    assign w_sum_sub = w_sum - {1'b0, r_d};

    // read address select
    always_comb begin
        w_rd_en   = 1'b1;
        w_rd_addr = r_low;
        case (w_uw.op)
            OP_RD_LO:  w_rd_addr = r_low;
            OP_RD_HI:  w_rd_addr = r_high;
            OP_RD_MID: w_rd_addr = r_mid;
            default:   w_rd_en   = 1'b0;
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx32[IW-1:0]] <= w_val64[VW-1:0];
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // jump condition
    always_comb begin
        unique case (w_uw.cond)
            C_NEXT:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_SEARCH: w_take = !(i_in_valid && i_in_word.req_type == REQ_SEARCH);
            C_EMPTY:     w_take = r_empty;
            C_LOOP_DONE: w_take = w_loop_done;
            C_CNT_NZ:    w_take = (r_cnt != '0);
            C_NE:        w_take = (r_key != r_rdata);
            C_KEY_EQ_LO: w_take = (r_key == r_vlo);
            C_OUT_FREE:  w_take = w_out_free;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + t_pc'(1);
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // datapath driven by the control word
    always_ff @(posedge i_clk) begin
        unique case (w_uw.op)
            OP_ACCEPT: begin
                r_key   <= w_key64[VW-1:0];
                r_low   <= w_start32[IW-1:0];
                r_high  <= w_last[IW-1:0];
                r_empty <= (w_endc <= w_start32);
            end
            OP_RD_HI: begin
                r_vlo <= r_rdata;
            end
            OP_CAP_HI: begin
                r_vhi <= r_rdata;
            end
            OP_INIT_DIV: begin
                r_a   <= r_key - r_vlo;
                r_d   <= r_vhi - r_vlo;
                r_n   <= r_high - r_low;
                r_q   <= '0;
                r_rem <= '0;
                r_cnt <= CNT_LAST;
            end
            OP_DBL: begin
                r_q   <= (r_q << 1) | IW'(w_dbl_ge);
                r_rem <= w_dbl_ge ? w_dbl_sub[VW-1:0] : w_dbl[VW-1:0];
            end
            OP_ADD: begin
                if (w_nbit) begin
                    r_q   <= r_q + IW'(w_sum_ge);
                    r_rem <= w_sum_ge ? w_sum_sub[VW-1:0] : w_sum[VW-1:0];
                end
                r_n   <= r_n << 1;
                r_cnt <= r_cnt - CNTW'(1);
            end
            OP_MID: begin
                r_mid <= r_low + r_q;
            end
            OP_CMP: begin
                if (r_key > r_rdata) begin
                    r_low <= r_mid + IW'(1);
                end else if (r_key < r_rdata) begin
                    r_high <= r_mid - IW'(1);
                end
                r_pos <= r_mid;
            end
            OP_SET_HIT: begin
                r_found <= 1'b1;
            end
            OP_SET_LO_POS: begin
                r_pos <= r_low;
            end
            OP_SET_MISS: begin
                r_found <= 1'b0;
                r_pos   <= '0;
            end
            default: begin
            end
        endcase
    end

    // output register
    assign w_pos32 = 32'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.op == OP_DELIVER && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.op == OP_DELIVER && w_out_free) begin
            r_out_word.found    <= r_found;
            r_out_word.position <= r_found ? w_pos32[9:0] : 10'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[hdl/isrch_checker.sv]
`include "interpolation_search_macros.svh"

module isrch_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input isrch_pkg::t_out_word o_out_word
);
    import isrch_pkg::*;

    // reset empties the output register
    `ISRCH_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid)

    // a miss always reports position zero
    `ISRCH_ASSERT(a_miss_pos_zero, (o_out_valid && !o_out_word.found) |-> (o_out_word.position == 10'd0))

    // a stalled result holds
    `ISRCH_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))

    // no result can appear right after a word is taken
    `ISRCH_ASSERT(a_no_instant_result, (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))

endmodule

bind interpolation_search isrch_checker u_isrch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

[verif/interpolation_search_tb.sv]
module interpolation_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isrch_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int HOLD_CYCLES = 1500;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_WORDS = 360;

    // expected-result tracking for the search block
    class search_scoreboard;
        bit [31:0] entries [DEPTH];
        t_out_word pending_results[$];
        int        errors = 0;
        int        results_seen = 0;

        task report(input string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        // interpolation search over the shadow table
        function t_out_word lookup_key(input t_in_word w);
            t_out_word   res;
            int unsigned lo, hi, stop, mid;
            bit [31:0]   key;
            bit [63:0]   span, offs;
            res = '0;
            key = w.search_key;
            stop = (w.range_end > DEPTH) ? DEPTH : w.range_end;
            if (stop <= w.range_start) return res;
            lo = w.range_start;
            hi = stop - 1;
            while (entries[hi] != entries[lo] && key >= entries[lo] && key <= entries[hi]) begin
                span = 64'(entries[hi]) - 64'(entries[lo]);
                offs = 64'(key) - 64'(entries[lo]);
                mid = lo + 32'((offs * 64'(hi - lo)) / span);
                if (key > entries[mid]) lo = mid + 1;
                else if (key < entries[mid]) hi = mid - 1;
                else begin
                    res.found = 1'b1;
                    res.position = mid[9:0];
                    return res;
                end
            end
            // final compare at the low end
            if (key == entries[lo]) begin
                res.found = 1'b1;
                res.position = lo[9:0];
            end
            return res;
        endfunction

        function void note_word(input t_in_word w);
            if (w.req_type == REQ_WRITE) entries[w.entry_index] = w.entry_value;
            else pending_results.insert(pending_results.size(), lookup_key(w));
        endfunction

        task check_result(input t_out_word got);
            t_out_word want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word found=%0b position=%0d",
                                 got.found, got.position));
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found)
                report($sformatf("found got %0b want %0b", got.found, want.found));
            if (got.position !== want.position)
                report($sformatf("position got %0d want %0d", got.position, want.position));
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    search_scoreboard sb;
    bit [31:0] tbl_image [DEPTH];
    int        words_sent = 0;
    bit        tx_no_idle = 1'b0;
    bit        rx_no_idle = 1'b0;
    bit        hold_req = 1'b0;

    interpolation_search dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic bit [31:0] rand_between(input bit [31:0] a, input bit [31:0] b);
        bit [63:0] n;
        if (a >= b) return a;
        n = 64'(b) - 64'(a) + 64'd1;
        return a + 32'({$urandom, $urandom} % n);
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w = {$urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic t_in_word write_word(input int unsigned idx, input bit [31:0] val);
        t_in_word w;
        w = random_word();
        w.req_type = REQ_WRITE;
        w.entry_index = idx[9:0];
        w.entry_value = val;
        return w;
    endfunction

    function automatic t_in_word search_word(input bit [31:0] key, input int unsigned start,
                                             input int unsigned stop);
        t_in_word w;
        w = random_word();
        w.req_type = REQ_SEARCH;
        w.search_key = key;
        w.range_start = start[9:0];
        w.range_end = stop[10:0];
        return w;
    endfunction

    // random search, mostly short ranges and keys taken from the table
    function automatic t_in_word rand_search();
        t_in_word    w;
        int unsigned start, stop, eff, pick;
        w = random_word();
        w.req_type = REQ_SEARCH;
        start = $urandom_range(0, DEPTH - 1);
        pick = $urandom_range(0, 99);
        if (pick < 70) stop = start + $urandom_range(1, 16);
        else if (pick < 85) stop = start + $urandom_range(17, 128);
        else if (pick < 92) stop = start + $urandom_range(129, 1100);
        else if (pick < 96) stop = $urandom_range(0, start);
        else stop = $urandom_range(DEPTH + 1, 2047);
        if (stop > 2047) stop = 2047;
        w.range_start = start[9:0];
        w.range_end = stop[10:0];
        eff = (stop > DEPTH) ? DEPTH : stop;
        if (eff > start) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) w.search_key = tbl_image[$urandom_range(start, eff - 1)];
            else if (pick < 75) w.search_key = rand_between(tbl_image[start], tbl_image[eff - 1]);
            else if (pick < 88)
                w.search_key = tbl_image[$urandom_range(start, eff - 1)] +
                               ($urandom_range(0, 1) ? 32'd1 : -32'd1);
        end
        return w;
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(input t_in_word w);
        int g;
        if (w.req_type == REQ_WRITE) tbl_image[w.entry_index] = w.entry_value;
        in_word <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_word(w);
        words_sent++;
        g = tx_no_idle ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // sender pause until all searches have answered
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    // rewrite a short segment with sorted values of a random shape
    task automatic reload_segment();
        int unsigned a, len, mode, i;
        bit [31:0]   lb, ub;
        bit [31:0]   vals[$];
        a = $urandom_range(0, DEPTH - 1);
        len = $urandom_range(1, 64);
        if (a + len > DEPTH) len = DEPTH - a;
        lb = (a > 0) ? tbl_image[a - 1] : 32'd0;
        ub = (a + len < DEPTH) ? tbl_image[a + len] : '1;
        if (lb > ub) ub = '1;
        mode = $urandom_range(0, 99);
        for (i = 0; i < len; i++) begin
            if (mode < 20) vals.insert(vals.size(), (i == 0) ? rand_between(lb, ub) : vals[0]);
            else if (mode < 45)
                vals.insert(vals.size(),
                            lb + 32'((64'(ub) - 64'(lb)) >> $urandom_range(0, 31)));
            else vals.insert(vals.size(), rand_between(lb, ub));
        end
        vals.sort();
        for (i = 0; i < len; i++) send_word(write_word(a + i, vals[i]));
    endtask

    // single write, sometimes breaking the order
    task automatic noise_write();
        int unsigned idx;
        bit [31:0]   lb, ub;
        idx = $urandom_range(0, DEPTH - 1);
        lb = (idx > 0) ? tbl_image[idx - 1] : 32'd0;
        ub = (idx < DEPTH - 1) ? tbl_image[idx + 1] : '1;
        if ($urandom_range(0, 9) < 6) send_word(write_word(idx, rand_between(lb, ub)));
        else send_word(write_word(idx, $urandom));
    endtask

    // receiver: check accepted words, random stalls, long hold on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n !== 1'b1) begin
                out_ready <= 1'b0;
            end else begin
                if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(out_word);
                if (hold_req) begin
                    hold_left = HOLD_CYCLES;
                    hold_req = 1'b0;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    out_ready <= 1'b0;
                end else if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if (!rx_no_idle && $urandom_range(0, 3) == 0) stall_left = gap_len();
                end
            end
        end
    end

    // stimulus
    initial begin
        int i;
        int burst;
        int goal;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the whole table in order, extremes at both ends
        for (i = 0; i < DEPTH - 1; i++) send_word(write_word(i, 32'(i) << 22));
        send_word(write_word(DEPTH - 1, '1));

        // directed searches
        send_word(search_word(32'd0, 0, DEPTH));
        send_word(search_word('1, 0, DEPTH));
        send_word(search_word(32'd500 << 22, 0, DEPTH));
        send_word(search_word((32'd500 << 22) + 32'd1, 0, DEPTH));
        // empty ranges
        send_word(search_word(32'd5 << 22, 5, 5));
        send_word(search_word(32'd5 << 22, 10, 3));
        send_word(search_word(32'd0, 0, 0));
        // range end past the table is clamped
        send_word(search_word('1, 1000, 2047));
        send_word(search_word($urandom, 1023, 2047));
        send_word(search_word('1, 1023, DEPTH));
        // key below and above the range values
        send_word(search_word(32'd50 << 22, 100, 200));
        send_word(search_word(32'd300 << 22, 100, 200));
        // run of equal values, searched inside the run and across it
        for (i = 600; i < 604; i++) send_word(write_word(i, 32'd601 << 22));
        send_word(search_word(32'd601 << 22, 600, 604));
        send_word(search_word(32'd601 << 22, 598, 606));
        send_word(search_word(32'd602 << 22, 600, 604));
        // duplicate at the top end
        send_word(write_word(DEPTH - 2, '1));
        send_word(search_word('1, 1000, DEPTH));
        send_word(search_word($urandom, 0, 2047));
        wait_idle();

        // random bursts of well-formed searches with some rewrites and noise
        goal = words_sent + RANDOM_WORDS;
        burst = 0;
        while (words_sent < goal) begin
            burst++;
            tx_no_idle = ($urandom_range(0, 5) == 0);
            rx_no_idle = ($urandom_range(0, 5) == 0);
            if (burst == 2) hold_req = 1'b1;
            if (burst == 5 || burst == 12) wait_idle();
            if ($urandom_range(0, 4) == 0) reload_segment();
            repeat ($urandom_range(4, 12)) begin
                if ($urandom_range(0, 9) == 0) noise_write();
                else send_word(rand_search());
            end
        end

        // drain and finish
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
